### design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the prime field modular ALU.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int VALUE_BITS = 30;
    localparam int EXP_BITS   = 64;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int S_TDATA_W  = ((2 * VALUE_BITS + EXP_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VALUE_BITS + 1 + 7) / 8) * 8;

    localparam logic [VALUE_BITS-1:0] MODULUS_RESET = VALUE_BITS'(536903681);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_POW = 3'd4,
        OP_INV = 3'd5,
        OP_CMP = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_MUL,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] x;
        logic [VALUE_BITS-1:0] y;
    } mul_req_t;

endpackage

### design/prime_field_modular_alu.sv
// ----------------------------------------------------------------------------
// prime_field_modular_alu
// Arithmetic over GF(p): add, sub, negate, multiply, power, inverse, compare.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per operation, op in s_tuser. s_tready is high only
//   while the unit is idle; one word is worked on at a time.
//   m_ channel: one result word per input word, held in an output register,
//   so a new input word is taken while the previous result waits.
//   cfg_wr_en/cfg_wr_data write the modulus; write only while idle.
// Sequence per op (all reductions and products run through one
// bit-serial modular multiplier):
//   modulus <= 1 or undefined op: straight to the result, no multiplier pass.
//   negate: reduce a. add, sub, compare: reduce a, b. multiply: also a * b.
//   power/inverse: reduce a, then per exponent bit up to the highest set bit
//   a multiply into the result if the bit is set and a square of the base.
// Reset clears the sequencer and output valid and loads the default modulus.
// When m_tready is low the result stays in place and the unit waits in its
// final state until the output register frees up.
// ----------------------------------------------------------------------------
module prime_field_modular_alu
    import pfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [VALUE_BITS-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // a, b, exponent, zero pad
    input  logic [2:0]            s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // result, equal, zero pad
);

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] modulus_reg;
    op_t                   op_reg;
    logic                  trivial_reg;
    logic [VALUE_BITS-1:0] a_reg;
    logic [VALUE_BITS-1:0] b_reg;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [EXP_BITS-1:0]   exp_reg;

    logic                  m_tvalid_reg;
    logic [VALUE_BITS-1:0] m_result_reg;
    logic                  m_equal_reg;

    mul_req_t              mul_req;
    logic                  mul_done;
    logic [VALUE_BITS-1:0] mul_product;

    logic                  accept;
    logic                  out_load;
    op_t                   op_in;
    logic                  op_known;
    logic                  trivial_in;
    logic                  needs_b;
    logic [VALUE_BITS-1:0] s_a;
    logic [VALUE_BITS-1:0] s_b;
    logic [EXP_BITS-1:0]   s_exp;
    logic [VALUE_BITS:0]   add_sum;
    logic [VALUE_BITS-1:0] res_next;
    logic                  eq_next;

    assign s_a   = s_tdata[VALUE_BITS-1:0];
    assign s_b   = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
    assign s_exp = s_tdata[2*VALUE_BITS+EXP_BITS-1:2*VALUE_BITS];
    assign op_in = op_t'(s_tuser);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        unique case (op_in)
            OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_POW, OP_INV, OP_CMP: op_known = 1'b1;
            default: op_known = 1'b0;
        endcase
        trivial_in = (modulus_reg <= VALUE_BITS'(1)) || !op_known;
    end

    always_comb begin
        unique case (op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_CMP: needs_b = 1'b1;
            default:                        needs_b = 1'b0;
        endcase
    end

    pfa_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .modulus (modulus_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = trivial_in ? S_DONE : S_RED_A;
            end
            S_RED_A: begin
                if (mul_done) begin
                    if (needs_b) state_next = S_RED_B;
                    else if (op_reg == OP_POW || op_reg == OP_INV) state_next = S_POW_CHK;
                    else state_next = S_DONE;
                end
            end
            S_RED_B: begin
                if (mul_done) state_next = (op_reg == OP_MUL) ? S_MUL : S_DONE;
            end
            S_MUL: begin
                if (mul_done) state_next = S_DONE;
            end
            S_POW_CHK: begin
                if (exp_reg == '0) state_next = S_DONE;
                else               state_next = exp_reg[0] ? S_POW_MUL : S_POW_SQR;
            end
            S_POW_MUL: begin
                if (mul_done) state_next = S_POW_SQR;
            end
            S_POW_SQR: begin
                if (mul_done) state_next = S_POW_CHK;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // multiplier requests
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.x     = VALUE_BITS'(1);
        mul_req.y     = s_a;
        unique case (state_reg)
            S_IDLE: begin
                mul_req.start = accept && !trivial_in;
            end
            S_RED_A: begin
                mul_req.start = mul_done && needs_b;
                mul_req.y     = b_reg;
            end
            S_RED_B: begin
                mul_req.start = mul_done && (op_reg == OP_MUL);
                mul_req.x     = a_reg;
                mul_req.y     = mul_product;
            end
            S_POW_CHK: begin
                mul_req.start = (exp_reg != '0);
                mul_req.x     = exp_reg[0] ? acc_reg : a_reg;
                mul_req.y     = a_reg;
            end
            S_POW_MUL: begin
                mul_req.start = mul_done;
                mul_req.x     = a_reg;
                mul_req.y     = a_reg;
            end
            S_MUL, S_POW_SQR, S_DONE: begin
                mul_req.start = 1'b0;
            end
            default: mul_req.start = 1'b0;
        endcase
    end

    // final result
    always_comb begin
        add_sum  = {1'b0, a_reg} + {1'b0, b_reg};
        res_next = '0;
        eq_next  = 1'b0;
        if (trivial_reg) begin
            eq_next = (op_reg == OP_CMP);
        end else begin
            unique case (op_reg)
                OP_ADD: res_next = (add_sum >= {1'b0, modulus_reg})
                                 ? VALUE_BITS'(add_sum - {1'b0, modulus_reg})
                                 : VALUE_BITS'(add_sum);
                OP_SUB: res_next = (a_reg >= b_reg) ? a_reg - b_reg
                                                    : a_reg + (modulus_reg - b_reg);
                OP_NEG: res_next = (a_reg == '0) ? '0 : modulus_reg - a_reg;
                OP_MUL, OP_POW, OP_INV: res_next = acc_reg;
                OP_CMP: eq_next = (a_reg == b_reg);
                default: res_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            modulus_reg  <= MODULUS_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) modulus_reg <= cfg_wr_data;
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= op_in;
            trivial_reg <= trivial_in;
            a_reg       <= s_a;
            b_reg       <= s_b;
            exp_reg     <= s_exp;
        end
        if (mul_done) begin
            unique case (state_reg)
                S_RED_A: begin
                    a_reg   <= mul_product;
                    acc_reg <= VALUE_BITS'(1);
                    if (op_reg == OP_INV) begin
                        exp_reg <= EXP_BITS'(modulus_reg - VALUE_BITS'(2));
                    end
                end
                S_RED_B:   b_reg   <= mul_product;
                S_MUL:     acc_reg <= mul_product;
                S_POW_MUL: acc_reg <= mul_product;
                S_POW_SQR: begin
                    a_reg   <= mul_product;
                    exp_reg <= exp_reg >> 1;
                end
                default: ;
            endcase
        end
        if (out_load) begin
            m_result_reg <= res_next;
            m_equal_reg  <= eq_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-VALUE_BITS-1){1'b0}}, m_equal_reg, m_result_reg};

endmodule

### design/pfa_modmul.sv
// ----------------------------------------------------------------------------
// pfa_modmul
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle,
// MSB first. x must be below m; y may be any value, so x = 1 reduces y.
// ----------------------------------------------------------------------------
module pfa_modmul
    import pfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mul_req_t              req,
    input  logic [VALUE_BITS-1:0] modulus,
    output logic                  done,
    output logic [VALUE_BITS-1:0] product
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [VALUE_BITS-1:0] x_reg;
    logic [VALUE_BITS-1:0] y_reg;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;

    logic [VALUE_BITS:0] mod_ext;
    logic [VALUE_BITS:0] dbl;
    logic [VALUE_BITS:0] dbl_red;
    logic [VALUE_BITS:0] sum;

    always_comb begin
        mod_ext  = {1'b0, modulus};
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
        sum      = dbl_red + (y_reg[VALUE_BITS-1] ? {1'b0, x_reg} : '0);
        acc_next = (sum >= mod_ext) ? VALUE_BITS'(sum - mod_ext) : VALUE_BITS'(sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(VALUE_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[VALUE_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### design/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks for the prime field modular ALU, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_checker
    import pfa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_equal_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[VALUE_BITS] |-> m_tdata[VALUE_BITS-1:0] == '0)
        else $error("equal flag with nonzero result");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

endmodule

bind prime_field_modular_alu pfa_checker u_pfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
